FILE: hw/rtl/trpl_pkg.sv
// ----------------------------------------------------------------------------
// trpl_pkg: shared types and constants of the region peak locator
// Register indexes, configuration bundle and result bundle used by every file.
// ----------------------------------------------------------------------------
package trpl_pkg;

   // Fixed field widths.
   localparam int THRESH_W  = 24;
   localparam int MINW_W    = 16;
   localparam int PPOS_W    = 17;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 24;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 8'd0,
      CSR_MIN_WIDTH = 8'd1
   } csr_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [THRESH_W-1:0] threshold;
      logic [MINW_W-1:0]   min_width;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic              has_point;
      logic [PPOS_W-1:0] point_position;
      logic              series_end;
      logic              rejected;
   } result_type;

endpackage

FILE: hw/rtl/threshold_region_peak_locator_unit.sv
// ----------------------------------------------------------------------------
// threshold_region_peak_locator_unit: change-point peak locator
// Finds regions above a threshold in a stream of statistic samples and
// reports the position of each wide-enough region's first maximum.
// ----------------------------------------------------------------------------
// The unit takes one sample request per clock and keeps that rate as long as
// the result side does not stall. Every request passes an input register,
// the tracking logic (a compare against the threshold, a peak update and an
// end-minus-start subtraction checked against the minimum width), and a
// result register. The result register is loaded when the request moves on
// from the input register, which holds the request while the result side
// stalls on a full result register. Only requests that close an accepted
// region or end a series produce a result; the others load nothing into the
// result register. Positions count from 0 inside a series, stop advancing
// at MAX_SERIES_LEN - 1, and are reported counting from 1. The threshold and
// minimum width registers must be written while no request is in flight.
module threshold_region_peak_locator_unit #(
   parameter int MAX_SERIES_LEN = 65536,
   parameter int SAMPLE_BITS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample requests.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  logic                                req_series_last,
   // Results.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_has_point,
   output logic [trpl_pkg::PPOS_W-1:0]         rsp_point_position,
   output logic                                rsp_series_end,
   output logic                                rsp_rejected,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [trpl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trpl_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import trpl_pkg::*;

   cfg_type    cfg;
   result_type track_result;
   logic       track_present;

   // Input register.
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic                   in_last_ff;

   // Result register.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   logic advance;
   logic step;

   // The input register moves on whenever the result register is empty or
   // being emptied in this cycle, so a request can enter every cycle.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   trpl_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_sample;
         in_last_ff   <= req_series_last;
      end
   end

   trpl_region_tracker #(
      .MAX_SERIES_LEN (MAX_SERIES_LEN),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .sample         (in_sample_ff),
      .series_last    (in_last_ff),
      .cfg            (cfg),
      .result_present (track_present),
      .result         (track_result)
   );

   // A request that produces no result simply empties the result register
   // if it was being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && track_present;
      end
   end

   always_ff @(posedge clock) begin
      if (step && track_present) begin
         rsp_data_ff <= track_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_has_point      = rsp_data_ff.has_point;
   assign rsp_point_position = rsp_data_ff.point_position;
   assign rsp_series_end     = rsp_data_ff.series_end;
   assign rsp_rejected       = rsp_data_ff.rejected;

endmodule

FILE: hw/rtl/trpl_csr_regs.sv
// ----------------------------------------------------------------------------
// trpl_csr_regs: configuration registers
// Holds the threshold and minimum region width; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module trpl_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [trpl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trpl_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output trpl_pkg::cfg_type                cfg
);
   import trpl_pkg::*;

   logic [THRESH_W-1:0] threshold_ff;
   logic [MINW_W-1:0]   min_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         min_width_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: begin
               threshold_ff <= csr_wdata[THRESH_W-1:0];
            end
            CSR_MIN_WIDTH: begin
               min_width_ff <= csr_wdata[MINW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.min_width = min_width_ff;

endmodule

FILE: hw/rtl/trpl_region_tracker.sv
// ----------------------------------------------------------------------------
// trpl_region_tracker: per-series region and peak tracking
// Updates the running series state for one sample and forms its result.
// ----------------------------------------------------------------------------
module trpl_region_tracker #(
   parameter int MAX_SERIES_LEN = 65536,
   parameter int SAMPLE_BITS    = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   series_last,
   input  trpl_pkg::cfg_type      cfg,
   output logic                   result_present,
   output trpl_pkg::result_type   result
);
   import trpl_pkg::*;

   localparam int POS_W  = (MAX_SERIES_LEN > 2) ? $clog2(MAX_SERIES_LEN) : 1;
   localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
   localparam int DIFF_W = (POS_W > MINW_W) ? POS_W : MINW_W;
   localparam int PP_W   = (POS_W > PPOS_W) ? POS_W : PPOS_W;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SERIES_LEN - 1);

   logic [POS_W-1:0]       position_ff, position_in;
   logic                   inside_ff, inside_in;
   logic [POS_W-1:0]       start_ff, start_in;
   logic [POS_W-1:0]       end_ff, end_in;
   logic [SAMPLE_BITS-1:0] peak_val_ff, peak_val_in;
   logic [POS_W-1:0]       peak_pos_ff, peak_pos_in;
   logic                   found_ff, found_in;

   logic              above;
   logic              close;
   logic              point;
   logic [DIFF_W-1:0] span;
   logic [PP_W-1:0]   ppos_wide;

   assign above = CMP_W'(sample) > CMP_W'(cfg.threshold);

   always_comb begin
      position_in = position_ff;
      inside_in   = inside_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      peak_val_in = peak_val_ff;
      peak_pos_in = peak_pos_ff;
      found_in    = found_ff;
      close       = 1'b0;
      point       = 1'b0;

      if (above) begin
         if (!inside_ff) begin
            inside_in   = 1'b1;
            start_in    = position_ff;
            peak_val_in = sample;
            peak_pos_in = position_ff;
         end else if (sample > peak_val_ff) begin
            peak_val_in = sample;
            peak_pos_in = position_ff;
         end
         end_in = position_ff;
      end else if (inside_ff) begin
         close = 1'b1;
      end
      if (series_last && inside_in) begin
         close = 1'b1;
      end

      span = DIFF_W'(end_in) - DIFF_W'(start_in);
      if (close) begin
         inside_in = 1'b0;
         if (span >= DIFF_W'(cfg.min_width)) begin
            point    = 1'b1;
            found_in = 1'b1;
         end
      end

      ppos_wide = PP_W'(peak_pos_in) + PP_W'(1);

      result_present        = point || series_last;
      result.has_point      = point;
      result.point_position = point ? ppos_wide[PPOS_W-1:0] : '0;
      result.series_end     = series_last;
      result.rejected       = series_last && found_in;

      // End of series clears the whole running state.
      if (series_last) begin
         position_in = '0;
         inside_in   = 1'b0;
         start_in    = '0;
         end_in      = '0;
         peak_val_in = '0;
         peak_pos_in = '0;
         found_in    = 1'b0;
      end else if (position_ff < POS_LAST) begin
         position_in = position_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         inside_ff   <= 1'b0;
         start_ff    <= '0;
         end_ff      <= '0;
         peak_val_ff <= '0;
         peak_pos_ff <= '0;
         found_ff    <= 1'b0;
      end else if (step) begin
         position_ff <= position_in;
         inside_ff   <= inside_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
         peak_val_ff <= peak_val_in;
         peak_pos_ff <= peak_pos_in;
         found_ff    <= found_in;
      end
   end

endmodule
